FILE: rtl/rcu_pkg.sv
// package with request/result types, codes and helpers for the reorder buffer commit unit
`timescale 1ns / 1ps

package rcu_pkg;

    localparam logic [3:0] STATION_NONE     = 4'hF;
    localparam logic [3:0] STATION_MAX      = 4'hA;
    localparam int         NUM_STATIONS     = 11;
    localparam logic [7:0] OP_HALT          = 8'h4C;
    localparam logic [2:0] KIND_LAST_RESULT = 3'h4;
    localparam logic [2:0] KIND_STORE       = 3'h5;
    localparam logic [2:0] KIND_BRANCH      = 3'h6;
    localparam logic [2:0] KIND_FLAGS       = 3'h7;

    localparam logic [1:0] EVENT_NONE       = 2'd0;
    localparam logic [1:0] EVENT_MISPREDICT = 2'd1;
    localparam logic [1:0] EVENT_EXCEPTION  = 2'd2;
    localparam logic [1:0] EVENT_HALT       = 2'd3;

    localparam int WE_REG   = 0;
    localparam int WE_FLAGS = 1;
    localparam int WE_STORE = 2;

    localparam int ST_STORE_READY = 0;
    localparam int ST_STORE_DONE  = 1;
    localparam int ST_MISPREDICT  = 2;

    localparam int FLAGS_VALID_BIT = 4;

    typedef struct packed {
        logic        head_valid;
        logic [4:0]  head_index;
        logic [3:0]  source_station;
        logic [7:0]  head_op;
        logic [7:0]  exception_in;
        logic [2:0]  kind;
        logic [3:0]  dest_reg;
        logic [31:0] data_value;
        logic [4:0]  flags_entry;
        logic [2:0]  status_bits;
        logic [31:0] head_pc;
        logic [31:0] target_address;
    } commit_in_t;

    typedef struct packed {
        logic        pop_res;
        logic [4:0]  commit_index;
        logic [2:0]  write_enables;
        logic [3:0]  reg_addr;
        logic [31:0] write_data;
        logic [3:0]  flags_value;
        logic [7:0]  store_op;
        logic [31:0] address_out;
        logic [1:0]  event_code;
        logic [7:0]  exception_out;
        logic [10:0] free_mask;
    } commit_out_t;

    function automatic logic [NUM_STATIONS-1:0] station_mask(input logic [3:0] station);
        logic [NUM_STATIONS-1:0] mask;
        begin
            mask = '0;
            if (station <= STATION_MAX)
            begin
                mask[station] = 1'b1;
            end
            return mask;
        end
    endfunction

endpackage

FILE: rtl/rcu_in_stage.sv
// input register stage holding one head request
`timescale 1ns / 1ps

module rcu_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rcu_pkg::commit_in_t in_data,
    input  logic                advance,
    output logic                stage_valid,
    output rcu_pkg::commit_in_t stage_data
);

    logic                valid_reg;
    logic                valid_next;
    rcu_pkg::commit_in_t data_reg;

    assign in_ready    = !valid_reg || advance;
    assign valid_next  = in_ready ? in_valid : valid_reg;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: rtl/rcu_commit.sv
// retirement decision logic and store handshake flags
`timescale 1ns / 1ps

module rcu_commit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  rcu_pkg::commit_in_t  head,
    output rcu_pkg::commit_out_t result
);

    logic store_in_progress_reg;
    logic store_in_progress_next;
    logic store_finished_reg;
    logic store_finished_next;
    logic store_req;

    always_comb
    begin
        result    = '0;
        store_req = 1'b0;
        if (head.head_valid)
        begin
            if (head.source_station == rcu_pkg::STATION_NONE)
            begin
                result.pop_res = 1'b1;
                if (head.head_op == rcu_pkg::OP_HALT)
                begin
                    result.event_code = rcu_pkg::EVENT_HALT;
                end
            end
            else if (head.exception_in != 8'd0)
            begin
                result.pop_res       = 1'b1;
                result.event_code    = rcu_pkg::EVENT_EXCEPTION;
                result.exception_out = head.exception_in;
                result.address_out   = head.head_pc;
                result.free_mask     = rcu_pkg::station_mask(head.source_station);
            end
            else if (head.kind <= rcu_pkg::KIND_LAST_RESULT || head.kind == rcu_pkg::KIND_FLAGS)
            begin
                if (head.kind <= rcu_pkg::KIND_LAST_RESULT
                    && head.dest_reg != rcu_pkg::STATION_NONE)
                begin
                    result.write_enables[rcu_pkg::WE_REG] = 1'b1;
                    result.reg_addr   = head.dest_reg;
                    result.write_data = head.data_value;
                end
                if (head.flags_entry[rcu_pkg::FLAGS_VALID_BIT])
                begin
                    result.write_enables[rcu_pkg::WE_FLAGS] = 1'b1;
                    result.flags_value = head.flags_entry[3:0];
                end
                result.pop_res   = 1'b1;
                result.free_mask = rcu_pkg::station_mask(head.source_station);
            end
            else if (head.kind == rcu_pkg::KIND_STORE)
            begin
                if (head.status_bits[rcu_pkg::ST_STORE_READY])
                begin
                    if (!store_in_progress_reg && !store_finished_reg)
                    begin
                        store_req = 1'b1;
                        result.write_enables[rcu_pkg::WE_STORE] = 1'b1;
                        result.address_out = head.target_address;
                        result.write_data  = head.data_value;
                        result.store_op    = head.head_op;
                    end
                    if (store_finished_reg)
                    begin
                        result.pop_res   = 1'b1;
                        result.free_mask = rcu_pkg::station_mask(head.source_station);
                    end
                end
            end
            else
            begin
                // branch
                if (head.status_bits[rcu_pkg::ST_MISPREDICT])
                begin
                    result.event_code  = rcu_pkg::EVENT_MISPREDICT;
                    result.address_out = head.target_address;
                end
                result.pop_res   = 1'b1;
                result.free_mask = rcu_pkg::station_mask(head.source_station);
            end
        end
        if (result.pop_res)
        begin
            result.commit_index = head.head_index;
        end
    end

    always_comb
    begin
        store_in_progress_next = store_in_progress_reg;
        store_finished_next    = store_finished_reg;
        if (result.event_code == rcu_pkg::EVENT_MISPREDICT
            || result.event_code == rcu_pkg::EVENT_EXCEPTION)
        begin
            store_in_progress_next = 1'b0;
            store_finished_next    = 1'b0;
        end
        else if (store_finished_reg && result.pop_res)
        begin
            store_in_progress_next = 1'b0;
            store_finished_next    = 1'b0;
        end
        else
        begin
            if (head.status_bits[rcu_pkg::ST_STORE_DONE] && store_in_progress_reg
                && !store_finished_reg)
            begin
                store_finished_next = 1'b1;
            end
            if (store_req)
            begin
                store_in_progress_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_in_progress_reg <= 1'b0;
            store_finished_reg    <= 1'b0;
        end
        else if (take)
        begin
            store_in_progress_reg <= store_in_progress_next;
            store_finished_reg    <= store_finished_next;
        end
    end

endmodule

FILE: rtl/rcu_out_stage.sv
// result register stage feeding the output channel
`timescale 1ns / 1ps

module rcu_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    input  rcu_pkg::commit_out_t stage_result,
    output logic                 advance,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rcu_pkg::commit_out_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    rcu_pkg::commit_out_t data_reg;

    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? stage_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            data_reg <= stage_result;
        end
    end

endmodule

FILE: rtl/rob_commit_unit_top.sv
// top level of the reorder buffer commit unit
//
//   channel   signals                      direction  content
//   in        in_valid in_ready in_data    into unit  view of the reorder buffer head
//   out       out_valid out_ready out_data out of unit one retirement result per request
//
// one request per cycle unless out stalls; each request is held in the input register
// the decision is a single combinational decode between the input and result registers
// reset clears both store flags and all valid bits
// a stall on out holds the result register and backs up into the input register
`timescale 1ns / 1ps

module rob_commit_unit_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rcu_pkg::commit_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rcu_pkg::commit_out_t out_data
);

    logic                 advance;
    logic                 stage_valid;
    rcu_pkg::commit_in_t  stage_data;
    rcu_pkg::commit_out_t stage_result;

    rcu_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    rcu_commit u_commit (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (stage_valid && advance),
        .head   (stage_data),
        .result (stage_result)
    );

    rcu_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_result (stage_result),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
